/* hw/rtl/swtt_pkg.sv */
// ----------------------------------------------------------------------------
// Software timer task table - shared definitions
// Slot kinds, operation codes, transfer payload types and default sizes.
// ----------------------------------------------------------------------------
package swtt_pkg;

   // Default sizes for the top level parameters
   localparam int SLOTS_DEF        = 64;
   localparam int HANDLER_BITS_DEF = 8;
   localparam int TIME_BITS_DEF    = 32;

   // Slot kind codes
   typedef logic [1:0] slot_kind_type;
   localparam slot_kind_type KIND_FREE      = 2'd0;
   localparam slot_kind_type KIND_IMMEDIATE = 2'd1;
   localparam slot_kind_type KIND_DELAYED   = 2'd2;
   localparam slot_kind_type KIND_PERIODIC  = 2'd3;

   // Request operation codes
   typedef logic [2:0] op_type;
   localparam op_type OP_IMMEDIATE      = 3'd0;
   localparam op_type OP_PERIODIC       = 3'd1;
   localparam op_type OP_DELAYED        = 3'd2;
   localparam op_type OP_DELAYED_UNIQUE = 3'd3;
   localparam op_type OP_TICK           = 3'd4;

   // Response kind codes
   localparam logic RSP_ACK  = 1'b0;
   localparam logic RSP_FIRE = 1'b1;

   // Request transfer payload
   typedef struct packed {
      op_type      op;
      logic [7:0]  handler_id;
      logic [31:0] time_value;
      logic [31:0] tick_delta;
   } req_type;

   // Response transfer payload
   typedef struct packed {
      logic       kind;
      logic       accepted;
      logic [7:0] fired_handler;
      logic [5:0] slot_index;
      logic       last;
   } rsp_type;

   // Control from the sequencer to the head update unit
   typedef struct packed {
      logic tick;   // apply the tick update to the head slot
      logic write;  // overwrite the head slot with the new entry
   } head_ctrl_type;

endpackage

/* hw/rtl/swtt_cell.sv */
// ----------------------------------------------------------------------------
// Task table cell
// Holds one slot of the table; loads its neighbour's slot on every shift.
// ----------------------------------------------------------------------------
module swtt_cell #(
   parameter int HANDLER_BITS = swtt_pkg::HANDLER_BITS_DEF,
   parameter int TIME_BITS    = swtt_pkg::TIME_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    shift,
   input  swtt_pkg::slot_kind_type nxt_kind,
   input  logic [HANDLER_BITS-1:0] nxt_handler,
   input  logic [TIME_BITS-1:0]    nxt_limit,
   input  logic [TIME_BITS-1:0]    nxt_elapsed,
   output swtt_pkg::slot_kind_type kind,
   output logic [HANDLER_BITS-1:0] handler,
   output logic [TIME_BITS-1:0]    limit,
   output logic [TIME_BITS-1:0]    elapsed
);
   import swtt_pkg::*;

   slot_kind_type             kind_ff, kind_in;
   logic [HANDLER_BITS-1:0]   handler_ff, handler_in;
   logic [TIME_BITS-1:0]      limit_ff, limit_in;
   logic [TIME_BITS-1:0]      elapsed_ff, elapsed_in;

   // Take the neighbour's slot on a shift, otherwise hold
   always_comb begin
      kind_in    = shift ? nxt_kind    : kind_ff;
      handler_in = shift ? nxt_handler : handler_ff;
      limit_in   = shift ? nxt_limit   : limit_ff;
      elapsed_in = shift ? nxt_elapsed : elapsed_ff;
   end

   // Only the kind needs clearing: a free slot's other fields are never used
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_FREE;
      end else begin
         kind_ff <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      handler_ff <= handler_in;
      limit_ff   <= limit_in;
      elapsed_ff <= elapsed_in;
   end

   assign kind    = kind_ff;
   assign handler = handler_ff;
   assign limit   = limit_ff;
   assign elapsed = elapsed_ff;

endmodule

/* hw/rtl/swtt_head.sv */
// ----------------------------------------------------------------------------
// Task table head update unit
// Updates the slot leaving the head cell: tick ageing and firing, or overwrite
// with a newly scheduled task.
// ----------------------------------------------------------------------------
module swtt_head #(
   parameter int HANDLER_BITS = swtt_pkg::HANDLER_BITS_DEF,
   parameter int TIME_BITS    = swtt_pkg::TIME_BITS_DEF
) (
   input  swtt_pkg::head_ctrl_type ctrl,
   input  swtt_pkg::slot_kind_type cur_kind,
   input  logic [HANDLER_BITS-1:0] cur_handler,
   input  logic [TIME_BITS-1:0]    cur_limit,
   input  logic [TIME_BITS-1:0]    cur_elapsed,
   input  swtt_pkg::slot_kind_type new_kind,
   input  logic [HANDLER_BITS-1:0] new_handler,
   input  logic [TIME_BITS-1:0]    new_limit,
   input  logic [TIME_BITS-1:0]    delta,
   output swtt_pkg::slot_kind_type upd_kind,
   output logic [HANDLER_BITS-1:0] upd_handler,
   output logic [TIME_BITS-1:0]    upd_limit,
   output logic [TIME_BITS-1:0]    upd_elapsed,
   output logic                    fire
);
   import swtt_pkg::*;

   logic [TIME_BITS:0]   sum;
   logic [TIME_BITS-1:0] aged;
   logic                 active;

   // Saturating add of the (already clamped) delta
   always_comb begin
      sum    = {1'b0, cur_elapsed} + {1'b0, delta};
      aged   = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
      active = (cur_kind != KIND_FREE) && (cur_handler != '0);
   end

   // Slot update
   always_comb begin
      upd_kind    = cur_kind;
      upd_handler = cur_handler;
      upd_limit   = cur_limit;
      upd_elapsed = cur_elapsed;
      fire        = 1'b0;
      if (ctrl.write) begin
         upd_kind    = new_kind;
         upd_handler = new_handler;
         upd_limit   = new_limit;
         upd_elapsed = '0;
      end else if (ctrl.tick && active) begin
         upd_elapsed = aged;
         if (cur_kind == KIND_IMMEDIATE) begin
            fire     = 1'b1;
            upd_kind = KIND_FREE;
         end else if (aged > cur_limit) begin
            fire = 1'b1;
            if (cur_kind == KIND_DELAYED) begin
               upd_kind = KIND_FREE;
            end else begin
               upd_elapsed = '0;
            end
         end
      end
   end

endmodule

/* hw/rtl/software_timer_task_table_unit.sv */
// ----------------------------------------------------------------------------
// Software timer task table
// Task slot table kept in a rotating ring of cells, with one update unit at
// the head and a sequencer for scheduling and tick scans.
// ----------------------------------------------------------------------------
// The table is a ring of SLOTS cells that rotates by one slot per cycle while
// an operation walks it through a single update unit, so every schedule and
// every nonzero tick walks the whole table in index order. A schedule
// operation searches the whole ring, hands over its acknowledgement, and when
// a slot was found rotates the new entry into place over a second full turn.
// A tick scans the whole ring and then hands over its final firing; a stalled
// response port pauses the ring while a firing waits. A tick with zero delta
// and the unused op codes leave the sequencer idle and give no response. The
// request port is stalled while an operation is in progress.
// ----------------------------------------------------------------------------
module software_timer_task_table_unit #(
   parameter int SLOTS        = swtt_pkg::SLOTS_DEF,
   parameter int HANDLER_BITS = swtt_pkg::HANDLER_BITS_DEF,
   parameter int TIME_BITS    = swtt_pkg::TIME_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  swtt_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output swtt_pkg::rsp_type rsp_payload
);
   import swtt_pkg::*;

   localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);
   localparam logic [63:0] TIME_MAX = {64{1'b1}} >> (64 - TIME_BITS);

   // Sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_ACK    = 3'd2;
   localparam logic [2:0] S_WRITE  = 3'd3;
   localparam logic [2:0] S_TICK   = 3'd4;
   localparam logic [2:0] S_FLUSH  = 3'd5;

   logic [2:0]               state_ff, state_in;
   logic [IDXW-1:0]          step_ff, step_in;
   op_type                   op_ff, op_in;
   logic [HANDLER_BITS-1:0]  handler_ff, handler_in;
   logic [TIME_BITS-1:0]     tval_ff, tval_in;
   logic [TIME_BITS-1:0]     delta_ff, delta_in;
   logic                     mfound_ff, mfound_in;
   logic [IDXW-1:0]          midx_ff, midx_in;
   logic                     ffound_ff, ffound_in;
   logic [IDXW-1:0]          fidx_ff, fidx_in;
   logic                     found_ff, found_in;
   logic [IDXW-1:0]          target_ff, target_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic [HANDLER_BITS-1:0]  pend_handler_ff, pend_handler_in;
   logic [IDXW-1:0]          pend_idx_ff, pend_idx_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   // Ring wiring
   slot_kind_type            ring_kind    [SLOTS];
   logic [HANDLER_BITS-1:0]  ring_handler [SLOTS];
   logic [TIME_BITS-1:0]     ring_limit   [SLOTS];
   logic [TIME_BITS-1:0]     ring_elapsed [SLOTS];
   slot_kind_type            upd_kind;
   logic [HANDLER_BITS-1:0]  upd_handler;
   logic [TIME_BITS-1:0]     upd_limit;
   logic [TIME_BITS-1:0]     upd_elapsed;
   logic                     fire;
   logic                     shift;
   head_ctrl_type            head_ctrl;
   slot_kind_type            new_kind;
   logic [TIME_BITS-1:0]     new_limit;

   logic                     req_xfer;
   logic                     out_free;
   logic                     last_step;
   logic                     rsp_load;
   logic [63:0]              tval_wide;
   logic [63:0]              delta_wide;
   logic [TIME_BITS-1:0]     tval_clamped;
   logic [TIME_BITS-1:0]     delta_clamped;
   logic                     is_free;
   logic                     is_match;

   // Handshake
   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_step = (step_ff == LAST_IDX);

   // Clamp incoming times to the TIME_BITS range
   always_comb begin
      tval_wide     = 64'(req_payload.time_value);
      delta_wide    = 64'(req_payload.tick_delta);
      tval_clamped  = TIME_BITS'((tval_wide  > TIME_MAX) ? TIME_MAX : tval_wide);
      delta_clamped = TIME_BITS'((delta_wide > TIME_MAX) ? TIME_MAX : delta_wide);
   end

   // New entry for the schedule operation in progress
   always_comb begin
      unique case (op_ff) inside
         OP_IMMEDIATE: begin
            new_kind  = KIND_IMMEDIATE;
            new_limit = '0;
         end
         OP_PERIODIC: begin
            new_kind  = KIND_PERIODIC;
            new_limit = tval_ff;
         end
         default: begin
            new_kind  = KIND_DELAYED;
            new_limit = tval_ff;
         end
      endcase
   end

   // Head control and ring advance
   always_comb begin
      head_ctrl.tick  = (state_ff == S_TICK);
      head_ctrl.write = (state_ff == S_WRITE) && (step_ff == target_ff);
      unique case (state_ff)
         S_SEARCH, S_WRITE: shift = 1'b1;
         S_TICK:            shift = !(fire && pend_valid_ff && !out_free);
         default:           shift = 1'b0;
      endcase
   end

   // Slot search at the head
   always_comb begin
      is_free   = (ring_kind[0] == KIND_FREE);
      is_match  = !is_free && (ring_handler[0] == handler_ff);
      mfound_in = mfound_ff | is_match;
      midx_in   = (!mfound_ff && is_match) ? step_ff : midx_ff;
      ffound_in = ffound_ff | is_free;
      fidx_in   = (!ffound_ff && is_free) ? step_ff : fidx_ff;
      if (op_ff == OP_DELAYED_UNIQUE) begin
         found_in  = mfound_in | ffound_in;
         target_in = mfound_in ? midx_in : fidx_in;
      end else begin
         found_in  = ffound_in;
         target_in = fidx_in;
      end
   end

   // Sequencer
   always_comb begin
      state_in        = state_ff;
      step_in         = step_ff;
      op_in           = op_ff;
      handler_in      = handler_ff;
      tval_in         = tval_ff;
      delta_in        = delta_ff;
      pend_valid_in   = pend_valid_ff;
      pend_handler_in = pend_handler_ff;
      pend_idx_in     = pend_idx_ff;
      rsp_load        = 1'b0;
      rsp_data_in     = rsp_data_ff;

      if (shift) begin
         step_in = last_step ? '0 : step_ff + 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               op_in         = req_payload.op;
               handler_in    = HANDLER_BITS'(req_payload.handler_id);
               tval_in       = tval_clamped;
               delta_in      = delta_clamped;
               step_in       = '0;
               pend_valid_in = 1'b0;
               unique case (req_payload.op) inside
                  OP_IMMEDIATE, OP_PERIODIC, OP_DELAYED, OP_DELAYED_UNIQUE: begin
                     state_in = S_SEARCH;
                  end
                  OP_TICK: begin
                     if (req_payload.tick_delta != '0) begin
                        state_in = S_TICK;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SEARCH: begin
            if (last_step) begin
               state_in = S_ACK;
            end
         end
         S_ACK: begin
            if (out_free) begin
               rsp_load                  = 1'b1;
               rsp_data_in.kind          = RSP_ACK;
               rsp_data_in.accepted      = found_ff;
               rsp_data_in.fired_handler = 8'(handler_ff);
               rsp_data_in.slot_index    = found_ff ? 6'(target_ff) : 6'd0;
               rsp_data_in.last          = 1'b1;
               state_in                  = found_ff ? S_WRITE : S_IDLE;
            end
         end
         S_WRITE: begin
            if (last_step) begin
               state_in = S_IDLE;
            end
         end
         S_TICK: begin
            if (shift && fire) begin
               // Hand the previous firing on; the newest waits for the last flag
               if (pend_valid_ff) begin
                  rsp_load                  = 1'b1;
                  rsp_data_in.kind          = RSP_FIRE;
                  rsp_data_in.accepted      = 1'b1;
                  rsp_data_in.fired_handler = 8'(pend_handler_ff);
                  rsp_data_in.slot_index    = 6'(pend_idx_ff);
                  rsp_data_in.last          = 1'b0;
               end
               pend_valid_in   = 1'b1;
               pend_handler_in = ring_handler[0];
               pend_idx_in     = step_ff;
            end
            if (shift && last_step) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_load                  = 1'b1;
               rsp_data_in.kind          = RSP_FIRE;
               rsp_data_in.accepted      = 1'b1;
               rsp_data_in.fired_handler = 8'(pend_handler_ff);
               rsp_data_in.slot_index    = 6'(pend_idx_ff);
               rsp_data_in.last          = 1'b1;
               pend_valid_in             = 1'b0;
               state_in                  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         step_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         mfound_ff     <= 1'b0;
         ffound_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (req_xfer) begin
            mfound_ff <= 1'b0;
            ffound_ff <= 1'b0;
         end else if (state_ff == S_SEARCH) begin
            mfound_ff <= mfound_in;
            ffound_ff <= ffound_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      handler_ff      <= handler_in;
      tval_ff         <= tval_in;
      delta_ff        <= delta_in;
      pend_handler_ff <= pend_handler_in;
      pend_idx_ff     <= pend_idx_in;
      rsp_data_ff     <= rsp_data_in;
      if (state_ff == S_SEARCH) begin
         midx_ff <= midx_in;
         fidx_ff <= fidx_in;
      end
      if ((state_ff == S_SEARCH) && last_step) begin
         found_ff  <= found_in;
         target_ff <= target_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // Head update unit between the head cell and the tail cell
   swtt_head #(
      .HANDLER_BITS (HANDLER_BITS),
      .TIME_BITS    (TIME_BITS)
   ) u_head (
      .ctrl        (head_ctrl),
      .cur_kind    (ring_kind[0]),
      .cur_handler (ring_handler[0]),
      .cur_limit   (ring_limit[0]),
      .cur_elapsed (ring_elapsed[0]),
      .new_kind    (new_kind),
      .new_handler (handler_ff),
      .new_limit   (new_limit),
      .delta       (delta_ff),
      .upd_kind    (upd_kind),
      .upd_handler (upd_handler),
      .upd_limit   (upd_limit),
      .upd_elapsed (upd_elapsed),
      .fire        (fire)
   );

   // Ring of cells: each loads its upper neighbour, the tail loads the head update
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      if (i == SLOTS - 1) begin : g_tail
         swtt_cell #(
            .HANDLER_BITS (HANDLER_BITS),
            .TIME_BITS    (TIME_BITS)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .shift       (shift),
            .nxt_kind    (upd_kind),
            .nxt_handler (upd_handler),
            .nxt_limit   (upd_limit),
            .nxt_elapsed (upd_elapsed),
            .kind        (ring_kind[i]),
            .handler     (ring_handler[i]),
            .limit       (ring_limit[i]),
            .elapsed     (ring_elapsed[i])
         );
      end else begin : g_body
         swtt_cell #(
            .HANDLER_BITS (HANDLER_BITS),
            .TIME_BITS    (TIME_BITS)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .shift       (shift),
            .nxt_kind    (ring_kind[i+1]),
            .nxt_handler (ring_handler[i+1]),
            .nxt_limit   (ring_limit[i+1]),
            .nxt_elapsed (ring_elapsed[i+1]),
            .kind        (ring_kind[i]),
            .handler     (ring_handler[i]),
            .limit       (ring_limit[i]),
            .elapsed     (ring_elapsed[i])
         );
      end
   end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Software timer task table - block level testbench
// Directed table of requests, a table fill, then random traffic. Every response
// transfer is checked against an in-bench copy of the slot table, with
// random idle cycles on the request side and random stalls on the response
// side.
// ----------------------------------------------------------------------------
module tb_top;
   import swtt_pkg::*;

   localparam int SLOTS        = SLOTS_DEF;
   localparam int RANDOM_ITEMS = 370;
   localparam int FILL_ITEMS   = 66;

   // Op codes the block ignores
   localparam op_type OP_RSVD_5 = 3'd5;
   localparam op_type OP_RSVD_6 = 3'd6;
   localparam op_type OP_RSVD_7 = 3'd7;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type ack;
   } dir_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   // Slot table as the testbench sees it
   slot_kind_type tab_kind    [SLOTS];
   logic [7:0]    tab_handler [SLOTS];
   logic [31:0]   tab_limit   [SLOTS];
   logic [31:0]   tab_elapsed [SLOTS];

   rsp_type pending_results [$];
   rsp_type new_results [$];

   int  requests_taken = 0;
   int  error_count    = 0;
   int  acks_seen      = 0;
   int  refused_seen   = 0;
   int  fires_seen     = 0;
   bit  quiet_phase    = 1'b0;
   bit  typed_pending  = 1'b0;
   rsp_type typed_value;

   software_timer_task_table_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      #150_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Idle length: mostly none or short, now and then long
   function automatic int idle_cycles();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 90);
   endfunction

   // Apply one request to the slot table and collect the responses it causes
   function automatic void timer_table_apply(input req_type r);
      int          found;
      int          idx;
      logic [32:0] sum;
      bit          fire;
      rsp_type     res;
      found = -1;
      if (r.op <= OP_DELAYED_UNIQUE) begin
         // slot search: first matching handler for unique, else first free
         for (int i = 0; i < SLOTS; i++) begin
            if (r.op == OP_DELAYED_UNIQUE && tab_kind[i] != KIND_FREE &&
                tab_handler[i] == r.handler_id) begin
               found = i;
               break;
            end
            if (found < 0 && tab_kind[i] == KIND_FREE) begin
               found = i;
               if (r.op != OP_DELAYED_UNIQUE) break;
            end
         end
         res.kind          = RSP_ACK;
         res.accepted      = (found >= 0);
         res.fired_handler = r.handler_id;
         res.slot_index    = '0;
         res.last          = 1'b1;
         if (found >= 0) begin
            res.slot_index       = 6'(found);
            tab_handler[found] = r.handler_id;
            tab_elapsed[found] = '0;
            case (r.op)
               OP_IMMEDIATE: begin
                  tab_kind[found]  = KIND_IMMEDIATE;
                  tab_limit[found] = '0;
               end
               OP_PERIODIC: begin
                  tab_kind[found]  = KIND_PERIODIC;
                  tab_limit[found] = r.time_value;
               end
               default: begin
                  tab_kind[found]  = KIND_DELAYED;
                  tab_limit[found] = r.time_value;
               end
            endcase
         end
         new_results.push_back(res);
      end else if (r.op == OP_TICK && r.tick_delta != '0) begin
         // tick scan in slot order, saturating elapsed counts
         for (int i = 0; i < SLOTS; i++) begin
            if (tab_kind[i] == KIND_FREE || tab_handler[i] == '0) continue;
            sum = {1'b0, tab_elapsed[i]} + {1'b0, r.tick_delta};
            tab_elapsed[i] = sum[32] ? '1 : sum[31:0];
            fire = 1'b0;
            if (tab_kind[i] == KIND_IMMEDIATE) begin
               fire        = 1'b1;
               tab_kind[i] = KIND_FREE;
            end else if (tab_elapsed[i] > tab_limit[i]) begin
               fire = 1'b1;
               if (tab_kind[i] == KIND_DELAYED) tab_kind[i] = KIND_FREE;
               else tab_elapsed[i] = '0;
            end
            if (fire) begin
               res.kind          = RSP_FIRE;
               res.accepted      = 1'b1;
               res.fired_handler = tab_handler[i];
               res.slot_index    = 6'(i);
               res.last          = 1'b0;
               new_results.push_back(res);
            end
         end
         if (new_results.size() > 0) begin
            idx = new_results.size() - 1;
            new_results[idx].last = 1'b1;
         end
      end
   endfunction

   // Field by field comparison of one response
   function automatic void compare_result(input rsp_type exp, input rsp_type got);
      if (got.kind !== exp.kind) begin
         $display("%0t: kind mismatch, expected %0d, got %0d", $time, exp.kind, got.kind);
         error_count++;
      end
      if (got.accepted !== exp.accepted) begin
         $display("%0t: accepted mismatch, expected %0d, got %0d",
                  $time, exp.accepted, got.accepted);
         error_count++;
      end
      if (got.fired_handler !== exp.fired_handler) begin
         $display("%0t: handler mismatch, expected 0x%02h, got 0x%02h",
                  $time, exp.fired_handler, got.fired_handler);
         error_count++;
      end
      if (got.slot_index !== exp.slot_index) begin
         $display("%0t: slot mismatch, expected %0d, got %0d",
                  $time, exp.slot_index, got.slot_index);
         error_count++;
      end
      if (got.last !== exp.last) begin
         $display("%0t: last mismatch, expected %0d, got %0d", $time, exp.last, got.last);
         error_count++;
      end
   endfunction

   // Monitor: request transfers feed the predictor, response transfers are checked
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            new_results.delete();
            timer_table_apply(req_payload);
            if (typed_pending) begin
               pending_results.push_back(typed_value);
               typed_pending = 1'b0;
            end else begin
               foreach (new_results[i]) pending_results.push_back(new_results[i]);
            end
            requests_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected response, got kind %0d handler 0x%02h slot %0d",
                        $time, rsp_payload.kind, rsp_payload.fired_handler,
                        rsp_payload.slot_index);
               error_count++;
            end else begin
               compare_result(pending_results.pop_front(), rsp_payload);
               if (rsp_payload.kind == RSP_FIRE) fires_seen++;
               else if (rsp_payload.accepted) acks_seen++;
               else refused_seen++;
            end
         end
      end
   end

   // Response side stalls
   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet_phase) begin
            hold = idle_cycles();
            if (hold > 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(negedge clock);
               rsp_stall <= 1'b0;
            end
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end
      end
   end

   // One request transfer, then an optional idle gap
   task automatic send_request(input req_type item, input bit typed, input rsp_type ack);
      int target;
      int gap;
      target        = requests_taken + 1;
      typed_pending = typed;
      typed_value   = ack;
      req_payload <= item;
      req_valid   <= 1'b1;
      do @(negedge clock); while (requests_taken != target);
      gap = quiet_phase ? 0 : idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic dir_row_type mk_row(input op_type op, input logic [7:0] h,
                                          input logic [31:0] tv, input logic [31:0] dv,
                                          input bit typed, input logic [5:0] slot);
      dir_row_type row;
      row.req.op             = op;
      row.req.handler_id     = h;
      row.req.time_value     = tv;
      row.req.tick_delta     = dv;
      row.typed              = typed;
      row.ack.kind           = RSP_ACK;
      row.ack.accepted       = 1'b1;
      row.ack.fired_handler  = h;
      row.ack.slot_index     = slot;
      row.ack.last           = 1'b1;
      return row;
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      p;
      p            = $urandom_range(0, 99);
      r.handler_id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
      r.time_value = ($urandom_range(0, 9) == 0) ? 32'($urandom)
                                                 : 32'($urandom_range(0, 120));
      if ($urandom_range(0, 19) == 0) r.time_value = '1;
      r.tick_delta = $urandom;
      if (p < 30) begin
         r.op = OP_TICK;
         p = $urandom_range(0, 99);
         if (p < 7) r.tick_delta = '0;
         else if (p < 12) r.tick_delta = '1;
         else if (p < 20) r.tick_delta = $urandom;
         else r.tick_delta = 32'($urandom_range(1, 40));
      end else if (p < 50) r.op = OP_IMMEDIATE;
      else if (p < 58) r.op = OP_PERIODIC;
      else if (p < 74) r.op = OP_DELAYED;
      else if (p < 95) r.op = OP_DELAYED_UNIQUE;
      else r.op = op_type'($urandom_range(OP_RSVD_5, OP_RSVD_7));
      return r;
   endfunction

   // Stimulus
   initial begin
      dir_row_type directed [18];
      req_type     item;
      rsp_type     no_ack;
      int          random_count;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      no_ack      = '0;
      foreach (tab_kind[i]) begin
         tab_kind[i]    = KIND_FREE;
         tab_handler[i] = '0;
         tab_limit[i]   = '0;
         tab_elapsed[i] = '0;
      end

      // Directed rows; acknowledgements typed in where the slot is obvious
      directed = '{
         mk_row(OP_IMMEDIATE,      8'hFF, 32'hFFFF_FFFF, 32'h0000_0000, 1, 6'd0),
         mk_row(OP_PERIODIC,       8'h01, 32'h0000_0000, 32'hFFFF_FFFF, 1, 6'd1),
         mk_row(OP_DELAYED,        8'h80, 32'hFFFF_FFFF, 32'h0000_0000, 1, 6'd2),
         mk_row(OP_DELAYED_UNIQUE, 8'h80, 32'h0000_0005, 32'h0000_0000, 1, 6'd2),
         mk_row(OP_DELAYED_UNIQUE, 8'hAA, 32'h0000_0003, 32'h0000_0000, 1, 6'd3),
         mk_row(OP_DELAYED,        8'h00, 32'h0000_0000, 32'h0000_0000, 1, 6'd4),
         mk_row(OP_TICK,           8'h00, 32'hFFFF_FFFF, 32'h0000_0000, 0, 6'd0),
         mk_row(OP_RSVD_5,         8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 6'd0),
         mk_row(OP_RSVD_6,         8'h00, 32'h0000_0000, 32'h0000_0001, 0, 6'd0),
         mk_row(OP_RSVD_7,         8'h55, 32'hAAAA_AAAA, 32'h5555_5555, 0, 6'd0),
         mk_row(OP_TICK,           8'h00, 32'h0000_0000, 32'h0000_0001, 0, 6'd0),
         mk_row(OP_TICK,           8'h00, 32'h0000_0000, 32'h0000_0003, 0, 6'd0),
         mk_row(OP_PERIODIC,       8'h7F, 32'hFFFF_FFFF, 32'h0000_0000, 1, 6'd0),
         mk_row(OP_TICK,           8'h00, 32'h0000_0000, 32'hFFFF_FFFF, 0, 6'd0),
         mk_row(OP_TICK,           8'h00, 32'h0000_0000, 32'hFFFF_FFFF, 0, 6'd0),
         mk_row(OP_DELAYED_UNIQUE, 8'h7F, 32'h0000_0000, 32'h0000_0000, 1, 6'd0),
         mk_row(OP_DELAYED_UNIQUE, 8'h00, 32'h0000_0001, 32'h0000_0000, 1, 6'd4),
         mk_row(OP_TICK,           8'h00, 32'h0000_0000, 32'h0000_0002, 0, 6'd0)
      };

      // Synchronous reset, released at a falling clock edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_request(directed[i].req, directed[i].typed, directed[i].ack);

      // Fill the table past full, then one saturating tick to fire the new delayed entries
      for (int i = 0; i < FILL_ITEMS; i++) begin
         item.op         = OP_DELAYED;
         item.handler_id = 8'($urandom_range(1, 255));
         item.time_value = 32'($urandom_range(0, 60));
         item.tick_delta = $urandom;
         send_request(item, 0, no_ack);
      end
      item.op         = OP_TICK;
      item.tick_delta = '1;
      send_request(item, 0, no_ack);
      random_count = FILL_ITEMS + 1;

      // Random phases, some with no idling on either side
      while (random_count < RANDOM_ITEMS) begin
         quiet_phase = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < 25 && random_count < RANDOM_ITEMS; k++) begin
            item = random_request();
            send_request(item, 0, no_ack);
            if (item.op <= OP_DELAYED_UNIQUE || (item.op == OP_TICK && item.tick_delta != '0))
               random_count++;
         end
      end
      quiet_phase = 1'b0;
      req_valid <= 1'b0;

      // Drain, then allow one full operation for stray responses
      while (pending_results.size() != 0) @(negedge clock);
      repeat (2 * SLOTS + 8) @(negedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, pending_results.size());
         error_count++;
      end

      $display("Run covered %0d requests: %0d slots taken, %0d refused, %0d firings checked.",
               requests_taken, acks_seen, refused_seen, fires_seen);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", error_count);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
